/* src/qvgm_pkg.sv */
// ----------------------------------------------------------------------------
// qvgm_pkg
// Shared types and constants for the quad vertex greedy matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package qvgm_pkg;

  localparam int unsigned COORD_BITS_DEF = 24;
  localparam int unsigned FACE_VERTS     = 4;
  localparam int unsigned AXES           = 3;
  localparam int unsigned VIDX_W         = $clog2(FACE_VERTS);
  localparam int unsigned SCAN_W         = 2 * VIDX_W;
  localparam int unsigned CNT_W          = SCAN_W + VIDX_W;
  localparam int unsigned PAIRS          = FACE_VERTS * FACE_VERTS;

  localparam logic [VIDX_W-1:0] LAST_VTX = VIDX_W'(FACE_VERTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_DRAIN,
    ST_MATCH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              wr_vtx;
    logic [VIDX_W-1:0] wr_pos;
    logic              sq_issue;
    logic [VIDX_W-1:0] sq_ref;
    logic              match_init;
    logic              scan_step;
    logic [SCAN_W-1:0] scan_idx;
    logic              emit;
    logic [VIDX_W-1:0] emit_slot;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

/* src/qvgm_ctrl.sv */
// ----------------------------------------------------------------------------
// qvgm_ctrl
// Sequencer: vertex intake, distance issue, greedy scan rounds, face emit.
// ----------------------------------------------------------------------------
`default_nettype none

module qvgm_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_tvalid,
  input  wire                in_chain_start,
  output logic               in_tready,
  output qvgm_pkg::dp_cmd_t  cmd,
  input  qvgm_pkg::dp_sts_t  sts
);

  qvgm_pkg::state_t                 state_r, state_nxt;
  logic [qvgm_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [qvgm_pkg::VIDX_W-1:0]      vcnt_r, vcnt_nxt;
  logic                             chain_valid_r, chain_valid_nxt;
  logic                             first_start_r, first_start_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= qvgm_pkg::ST_IDLE;
      cnt_r         <= '0;
      vcnt_r        <= '0;
      chain_valid_r <= 1'b0;
      first_start_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      vcnt_r        <= vcnt_nxt;
      chain_valid_r <= chain_valid_nxt;
      first_start_r <= first_start_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    vcnt_nxt        = vcnt_r;
    chain_valid_nxt = chain_valid_r;
    first_start_nxt = first_start_r;
    cmd             = '0;
    in_tready       = 1'b0;
    unique case (state_r)
      qvgm_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.wr_vtx = 1'b1;
          cmd.wr_pos = vcnt_r;
          vcnt_nxt   = vcnt_r + qvgm_pkg::VIDX_W'(1);
          if (vcnt_r == '0) begin
            first_start_nxt = in_chain_start;
          end
          cnt_nxt   = '0;
          state_nxt = qvgm_pkg::ST_DIST;
        end
      end
      qvgm_pkg::ST_DIST: begin
        cmd.sq_issue = 1'b1;
        cmd.sq_ref   = cnt_r[qvgm_pkg::VIDX_W-1:0];
        cnt_nxt      = cnt_r + qvgm_pkg::CNT_W'(1);
        if (cnt_r[qvgm_pkg::VIDX_W-1:0] == qvgm_pkg::LAST_VTX) begin
          state_nxt = qvgm_pkg::ST_DRAIN;
        end
      end
      qvgm_pkg::ST_DRAIN: begin
        cnt_nxt = '0;
        if (vcnt_r == '0) begin
          cmd.match_init = 1'b1;
          if (chain_valid_r && !first_start_r) begin
            state_nxt = qvgm_pkg::ST_MATCH;
          end else begin
            state_nxt = qvgm_pkg::ST_EMIT;
          end
        end else begin
          state_nxt = qvgm_pkg::ST_IDLE;
        end
      end
      qvgm_pkg::ST_MATCH: begin
        cmd.scan_step = 1'b1;
        cmd.scan_idx  = cnt_r[qvgm_pkg::SCAN_W-1:0];
        cnt_nxt       = cnt_r + qvgm_pkg::CNT_W'(1);
        if (cnt_r == '1) begin
          state_nxt = qvgm_pkg::ST_EMIT;
        end
      end
      qvgm_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_slot = cnt_r[qvgm_pkg::VIDX_W-1:0];
          cnt_nxt       = cnt_r + qvgm_pkg::CNT_W'(1);
          if (cnt_r[qvgm_pkg::VIDX_W-1:0] == qvgm_pkg::LAST_VTX) begin
            chain_valid_nxt = 1'b1;
            state_nxt       = qvgm_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = qvgm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/qvgm_dp.sv */
// ----------------------------------------------------------------------------
// qvgm_dp
// Face storage, squared-distance unit, greedy minimum scan and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qvgm_dp #(
  parameter int unsigned COORD_BITS = qvgm_pkg::COORD_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire        [COORD_BITS-1:0]  in_x,
  input  wire        [COORD_BITS-1:0]  in_y,
  input  wire        [COORD_BITS-1:0]  in_z,
  input  qvgm_pkg::dp_cmd_t            cmd,
  output qvgm_pkg::dp_sts_t            sts,
  input  wire                          out_tready,
  output logic                         out_tvalid,
  output logic       [COORD_BITS-1:0]  out_x,
  output logic       [COORD_BITS-1:0]  out_y,
  output logic       [COORD_BITS-1:0]  out_z,
  output logic                         out_last
);

  localparam int unsigned MW  = COORD_BITS + 1;
  localparam int unsigned SQW = 2 * COORD_BITS + 1;
  localparam int unsigned DW  = SQW + 2;
  localparam int unsigned VW  = qvgm_pkg::VIDX_W;

  typedef logic [qvgm_pkg::AXES-1:0][COORD_BITS-1:0] vtx_t;

  vtx_t                 inc_r [qvgm_pkg::FACE_VERTS];
  vtx_t                 ref_r [qvgm_pkg::FACE_VERTS];
  vtx_t                 cur_r;
  logic [VW-1:0]        cur_pos_r;

  logic [SQW-1:0]       sq_r [qvgm_pkg::AXES];
  logic [SQW-1:0]       sq_nxt [qvgm_pkg::AXES];
  logic                 sq_valid_r;
  logic [VW-1:0]        sq_idx_r;

  logic [DW-1:0]        dist_r [qvgm_pkg::PAIRS];

  logic [qvgm_pkg::FACE_VERTS-1:0] ref_used_r, cur_used_r;
  logic [VW-1:0]        map_r [qvgm_pkg::FACE_VERTS];
  logic [DW-1:0]        best_d_r, best_d_nxt;
  logic [VW-1:0]        best_i_r, best_i_nxt;
  logic [VW-1:0]        best_j_r, best_j_nxt;
  logic                 found_r, found_nxt;

  logic                 out_valid_r;
  vtx_t                 out_v_r;
  logic                 out_last_r;

  vtx_t                 ref_sel;
  vtx_t                 emit_v;
  logic [VW-1:0]        scan_i, scan_j;
  logic [DW-1:0]        scan_d;
  logic                 cand_ok, base_found, take;

  assign ref_sel = ref_r[cmd.sq_ref];
  assign emit_v  = inc_r[map_r[cmd.emit_slot]];

  always_comb begin
    logic [MW-1:0]   diff;
    logic [MW-1:0]   mag;
    logic [2*MW-1:0] prod;
    for (int k = 0; k < qvgm_pkg::AXES; k++) begin
      diff = {ref_sel[k][COORD_BITS-1], ref_sel[k]} - {cur_r[k][COORD_BITS-1], cur_r[k]};
      mag  = diff[MW-1] ? (~diff + MW'(1)) : diff;
      prod = mag * mag;
      sq_nxt[k] = prod[SQW-1:0];
    end
  end

  assign scan_i     = cmd.scan_idx[qvgm_pkg::SCAN_W-1:VW];
  assign scan_j     = cmd.scan_idx[VW-1:0];
  assign scan_d     = dist_r[cmd.scan_idx];
  assign cand_ok    = !ref_used_r[scan_i] && !cur_used_r[scan_j];
  assign base_found = (cmd.scan_idx != '0) && found_r;
  assign take       = cand_ok && (!base_found || (scan_d < best_d_r));

  always_comb begin
    best_d_nxt = best_d_r;
    best_i_nxt = best_i_r;
    best_j_nxt = best_j_r;
    found_nxt  = base_found || cand_ok;
    if (take) begin
      best_d_nxt = scan_d;
      best_i_nxt = scan_i;
      best_j_nxt = scan_j;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_vtx) begin
      inc_r[cmd.wr_pos] <= {in_z, in_y, in_x};
      cur_r             <= {in_z, in_y, in_x};
      cur_pos_r         <= cmd.wr_pos;
    end
    if (cmd.sq_issue) begin
      sq_r     <= sq_nxt;
      sq_idx_r <= cmd.sq_ref;
    end
    if (sq_valid_r) begin
      dist_r[{sq_idx_r, cur_pos_r}] <= DW'(sq_r[0]) + DW'(sq_r[1]) + DW'(sq_r[2]);
    end
    if (cmd.match_init) begin
      ref_used_r <= '0;
      cur_used_r <= '0;
      for (int i = 0; i < qvgm_pkg::FACE_VERTS; i++) begin
        map_r[i] <= VW'(i);
      end
    end
    if (cmd.scan_step) begin
      best_d_r <= best_d_nxt;
      best_i_r <= best_i_nxt;
      best_j_r <= best_j_nxt;
      found_r  <= found_nxt;
      if (cmd.scan_idx == '1) begin
        ref_used_r[best_i_nxt] <= 1'b1;
        cur_used_r[best_j_nxt] <= 1'b1;
        map_r[best_i_nxt]      <= best_j_nxt;
      end
    end
    if (cmd.emit) begin
      out_v_r                <= emit_v;
      out_last_r             <= (cmd.emit_slot == qvgm_pkg::LAST_VTX);
      ref_r[cmd.emit_slot]   <= emit_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sq_valid_r <= cmd.sq_issue;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_x        = out_v_r[0];
  assign out_y        = out_v_r[1];
  assign out_z        = out_v_r[2];
  assign out_last     = out_last_r;

endmodule

`default_nettype wire

/* src/quad_vertex_greedy_matcher.sv */
// ----------------------------------------------------------------------------
// quad_vertex_greedy_matcher
// Groups vertices into quad faces and reorders each face to line up with the
// face emitted before it, by greedy pairing on squared distance.
// ----------------------------------------------------------------------------
//  channel | ports                          | payload
//  input   | in_tvalid/in_tready/in_tdata   | x, y, z; in_tuser = chain start
//  output  | out_tvalid/out_tready/out_tdata| x, y, z; out_tlast = face end
//
//  Each vertex is taken in, then compared with the four reference vertices
//  through the shared three-axis squarer (one reference vertex per cycle);
//  the squares are registered and summed into the distance table. A matched
//  face adds a greedy scan, four rounds over 16 distances.
//  Synchronous active-low reset clears the controller; no clearing pass.
//  A low out_tready holds the face emit; a new vertex is taken while the last
//  result still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module quad_vertex_greedy_matcher #(
  parameter int unsigned COORD_BITS = qvgm_pkg::COORD_BITS_DEF,
  localparam int unsigned TDW = ((3 * COORD_BITS + 7) / 8) * 8
) (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_tvalid,
  output logic           in_tready,
  input  wire  [TDW-1:0] in_tdata,   // coord_x, coord_y, coord_z, zero pad
  input  wire            in_tuser,   // chain_start
  output logic           out_tvalid,
  input  wire            out_tready,
  output logic [TDW-1:0] out_tdata,  // out_x, out_y, out_z, zero pad
  output logic           out_tlast   // face_last
);

  qvgm_pkg::dp_cmd_t     cmd;
  qvgm_pkg::dp_sts_t     sts;
  logic [COORD_BITS-1:0] ox, oy, oz;

  qvgm_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_chain_start (in_tuser),
    .in_tready      (in_tready),
    .cmd            (cmd),
    .sts            (sts)
  );

  qvgm_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_x       (in_tdata[COORD_BITS-1:0]),
    .in_y       (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .in_z       (in_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_x      (ox),
    .out_y      (oy),
    .out_z      (oz),
    .out_last   (out_tlast)
  );

  assign out_tdata = TDW'({oz, oy, ox});

endmodule

`default_nettype wire

/* src/qvgm_chk.sv */
// ----------------------------------------------------------------------------
// qvgm_chk
// Port-level checks for the quad vertex greedy matcher, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module qvgm_chk #(
  parameter int unsigned TDW = 72
) (
  input wire           clk,
  input wire           rst_n,
  input wire           in_tvalid,
  input wire           in_tready,
  input wire           out_tvalid,
  input wire           out_tready,
  input wire [TDW-1:0] out_tdata,
  input wire           out_tlast
);

  logic in_xfer, out_xfer;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("output payload changed while stalled");

  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("in_tready held high after a vertex transfer");

  a_face_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && !out_tlast |=> out_tvalid)
    else $error("face emit broke before its last vertex");

endmodule

bind quad_vertex_greedy_matcher qvgm_chk #(
  .TDW (TDW)
) u_qvgm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

/* tb/quad_vertex_greedy_matcher_tb.sv */
// ----------------------------------------------------------------------------
// quad_vertex_greedy_matcher_tb
// Streams vertices into the quad matcher and checks every reordered vertex
// against a face-level greedy pairing predictor kept inside this module.
// Directed faces cover coordinate extremes, chain starts, ties and a missing
// reference; random chains follow the previous face with jitter and shuffle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module quad_vertex_greedy_matcher_tb;

  localparam int unsigned CW    = qvgm_pkg::COORD_BITS_DEF;
  localparam int          FACE_VERTS = qvgm_pkg::FACE_VERTS;
  localparam int unsigned TDW   = ((3 * CW + 7) / 8) * 8;
  localparam int          LIMIT = 200000;
  localparam int          HOLD_CYCLES = 300;
  localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  typedef logic [3*CW-1:0] vertex_t;   // x, y, z from the lowest bit up

  typedef struct {
    vertex_t xyz;
    logic    last;
  } out_vertex_t;

  typedef enum int {
    FACE_FRESH,
    FACE_FOLLOW,
    FACE_TIE
  } face_kind_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_tvalid = 1'b0;
  logic           in_tready;
  logic [TDW-1:0] in_tdata = '0;   // coord_x, coord_y, coord_z
  logic           in_tuser = 1'b0; // chain_start
  logic           out_tvalid;
  logic           out_tready = 1'b0;
  logic [TDW-1:0] out_tdata;       // out_x, out_y, out_z
  logic           out_tlast;       // face_last

  int  cycle_cnt = 0;
  int  err_cnt = 0;
  bit  quiet = 1'b0;
  bit  hold_off_go = 1'b0;
  int  hold_left = 0;

  // predictor state
  vertex_t ref_face [FACE_VERTS];
  vertex_t cur_face [FACE_VERTS];
  int      vtx_pos = 0;
  bit      have_ref = 1'b0;
  bit      face_start = 1'b0;
  out_vertex_t reordered_q [$];

  // stimulus state
  vertex_t face_buf [FACE_VERTS];
  vertex_t prev_face [FACE_VERTS];

  out_vertex_t exp_v;

  quad_vertex_greedy_matcher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results pending", cycle_cnt, reordered_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_error(input string msg);
    $display("ERROR cycle %0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  function automatic logic [65:0] dist_sq(input vertex_t a, input vertex_t b);
    logic [65:0] acc;
    longint      d;
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      d = longint'($signed(a[k*CW +: CW])) - longint'($signed(b[k*CW +: CW]));
      acc += 66'(d * d);
    end
    return acc;
  endfunction

  function automatic void predict_reorder(input vertex_t v, input bit start);
    int          map [FACE_VERTS];
    bit          ref_used [FACE_VERTS];
    bit          cur_used [FACE_VERTS];
    bit          found;
    int          bi, bj;
    logic [65:0] best, dd;
    out_vertex_t o;
    cur_face[vtx_pos] = v;
    if (vtx_pos == 0) face_start = start;
    if (vtx_pos != FACE_VERTS - 1) begin
      vtx_pos++;
      return;
    end
    vtx_pos = 0;
    for (int i = 0; i < FACE_VERTS; i++) begin
      map[i] = i;
      ref_used[i] = 1'b0;
      cur_used[i] = 1'b0;
    end
    if (have_ref && !face_start) begin
      for (int r = 0; r < FACE_VERTS; r++) begin
        found = 1'b0;
        bi = 0;
        bj = 0;
        best = '0;
        for (int i = 0; i < FACE_VERTS; i++) begin
          if (!ref_used[i]) begin
            for (int j = 0; j < FACE_VERTS; j++) begin
              if (!cur_used[j]) begin
                dd = dist_sq(ref_face[i], cur_face[j]);
                if (!found || dd < best) begin
                  found = 1'b1;
                  bi = i;
                  bj = j;
                  best = dd;
                end
              end
            end
          end
        end
        ref_used[bi] = 1'b1;
        cur_used[bj] = 1'b1;
        map[bi] = bj;
      end
    end
    for (int i = 0; i < FACE_VERTS; i++) begin
      o.xyz = cur_face[map[i]];
      o.last = (i == FACE_VERTS - 1);
      reordered_q.insert(reordered_q.size(), o);
    end
    for (int i = 0; i < FACE_VERTS; i++) ref_face[i] = cur_face[map[i]];
    have_ref = 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (reordered_q.size() == 0) begin
        report_error($sformatf("unexpected transfer data=%h last=%b", out_tdata, out_tlast));
      end else begin
        exp_v = reordered_q.pop_front();
        for (int k = 0; k < 3; k++) begin
          if (out_tdata[k*CW +: CW] !== exp_v.xyz[k*CW +: CW])
            report_error($sformatf("axis %0d got %h expected %h", k,
                                   out_tdata[k*CW +: CW], exp_v.xyz[k*CW +: CW]));
        end
        if (out_tlast !== exp_v.last)
          report_error($sformatf("tlast got %b expected %b", out_tlast, exp_v.last));
      end
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_off_go) begin
      hold_left = HOLD_CYCLES;
      hold_off_go = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (quiet) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= 15);
    end
  end

  function automatic vertex_t mk(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                 input logic [CW-1:0] z);
    return {z, y, x};
  endfunction

  function automatic vertex_t rand_vertex();
    logic [95:0] r;
    r = {$urandom(), $urandom(), $urandom()};
    return r[3*CW-1:0];
  endfunction

  function automatic logic [CW-1:0] nudge(input logic [CW-1:0] c, input int amp);
    int d;
    d = int'($urandom_range(0, 2 * amp)) - amp;
    return c + d[CW-1:0];
  endfunction

  // starts and ends at a falling edge
  task automatic send_vertex(input vertex_t v, input bit start);
    while (!quiet && $urandom_range(0, 99) < 15) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= TDW'(v);
    in_tuser <= start;
    do @(posedge clk); while (!in_tready);
    predict_reorder(v, start);
    @(negedge clk);
  endtask

  // late_mode: 0 later vertices flag low, 1 flag high, 2 random
  task automatic send_face(input bit start, input int late_mode);
    bit flag;
    for (int i = 0; i < FACE_VERTS; i++) begin
      if (i == 0) flag = start;
      else if (late_mode == 2) flag = $urandom_range(0, 1);
      else flag = (late_mode == 1);
      send_vertex(face_buf[i], flag);
    end
    for (int i = 0; i < FACE_VERTS; i++) prev_face[i] = face_buf[i];
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    wait (reordered_q.size() == 0);
    @(negedge clk);
  endtask

  task automatic make_face(input face_kind_t kind);
    int      amp, k;
    vertex_t t;
    case (kind)
      FACE_FRESH: begin
        for (int i = 0; i < FACE_VERTS; i++) face_buf[i] = rand_vertex();
      end
      FACE_TIE: begin
        for (int i = 0; i < FACE_VERTS; i++)
          face_buf[i] = mk(nudge('0, 2), nudge('0, 2), nudge('0, 2));
      end
      default: begin
        case ($urandom_range(0, 2))
          0: amp = 4;
          1: amp = 256;
          default: amp = 65536;
        endcase
        for (int i = 0; i < FACE_VERTS; i++)
          face_buf[i] = mk(nudge(prev_face[i][0 +: CW], amp),
                           nudge(prev_face[i][CW +: CW], amp),
                           nudge(prev_face[i][2*CW +: CW], amp));
        for (int i = FACE_VERTS - 1; i > 0; i--) begin
          k = $urandom_range(0, i);
          t = face_buf[i];
          face_buf[i] = face_buf[k];
          face_buf[k] = t;
        end
      end
    endcase
  endtask

  task automatic random_face();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      make_face(FACE_FRESH);
      send_face(1'b1, 2);
    end else if (r < 20) begin
      make_face(FACE_FRESH);
      send_face(1'b0, 2);
    end else if (r < 30) begin
      make_face(FACE_TIE);
      send_face(1'b0, 2);
    end else begin
      make_face(FACE_FOLLOW);
      send_face($urandom_range(0, 99) < 5, 2);
    end
  endtask

  task automatic test_directed();
    // no reference yet: passes unchanged even without a chain start
    face_buf[0] = mk(CMAX, CMAX, CMAX);
    face_buf[1] = mk(CMIN, CMIN, CMIN);
    face_buf[2] = mk('0, '0, '0);
    face_buf[3] = mk(CMAX, CMIN, '0);
    send_face(1'b0, 0);
    // permuted copy, chain start on later vertices is ignored
    face_buf[0] = mk('0, '0, '0);
    face_buf[1] = mk(CMAX, CMIN, '0);
    face_buf[2] = mk(CMIN, CMIN, CMIN);
    face_buf[3] = mk(CMAX, CMAX, CMAX);
    send_face(1'b0, 1);
    // new chain: passes unchanged
    face_buf[0] = mk(24'hAAAAAA, 24'h555555, 24'hAAAAAA);
    face_buf[1] = mk(24'h555555, 24'hAAAAAA, 24'h555555);
    face_buf[2] = mk(24'h000001, 24'hFFFFFF, 24'h000001);
    face_buf[3] = mk(24'hFFFFFF, 24'h000001, 24'hFFFFFF);
    send_face(1'b1, 0);
    // four identical vertices: all current vertices tie against each reference vertex
    for (int i = 0; i < FACE_VERTS; i++) face_buf[i] = mk(24'd5, 24'd5, 24'd5);
    send_face(1'b0, 0);
    // identical reference: ties on reference index, duplicate current vertices
    face_buf[0] = mk(24'd9, 24'd5, 24'd5);
    face_buf[1] = mk(24'd6, 24'd5, 24'd5);
    face_buf[2] = mk(24'd6, 24'd5, 24'd5);
    face_buf[3] = mk(24'd1, 24'd5, 24'd5);
    send_face(1'b0, 0);
    // far corner against small reference
    face_buf[0] = mk(CMIN, CMAX, CMIN);
    face_buf[1] = mk(CMAX, CMIN, CMAX);
    face_buf[2] = mk(CMIN, CMIN, CMAX);
    face_buf[3] = mk(CMAX, CMAX, CMIN);
    send_face(1'b0, 0);
  endtask

  task automatic test_random_chains(input int n_faces);
    for (int f = 0; f < n_faces; f++) random_face();
  endtask

  task automatic test_backpressure();
    in_tvalid <= 1'b0;
    @(posedge clk);
    hold_off_go = 1'b1;
    @(negedge clk);
    for (int f = 0; f < 3; f++) random_face();
    wait_drain();
    for (int f = 0; f < 2; f++) random_face();
  endtask

  task automatic test_quiet_stretch(input int n_faces);
    quiet = 1'b1;
    for (int f = 0; f < n_faces; f++) random_face();
    quiet = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < FACE_VERTS; i++) prev_face[i] = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    wait_drain();
    test_random_chains(25);
    test_backpressure();
    test_quiet_stretch(10);
    test_random_chains(25);
    in_tvalid <= 1'b0;
    wait (reordered_q.size() == 0);
    repeat (100) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/qvgm_pkg.sv
src/qvgm_ctrl.sv
src/qvgm_dp.sv
src/quad_vertex_greedy_matcher.sv
src/qvgm_chk.sv
tb/quad_vertex_greedy_matcher_tb.sv
